@@ rtl/mppa_pkg.sv @@
`default_nettype none
package mppa_pkg;

  // datapath width and fixed port field widths
  localparam int WIDTH   = 64;
  localparam int FIELD_W = 64;
  localparam int CNT_W   = $clog2(WIDTH);
  localparam int OP_W    = 3;

  typedef logic [WIDTH-1:0] word_t;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_NEG = 3'd4;
  localparam logic [OP_W-1:0] OP_CMP = 3'd5;

  // compare codes
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;
  localparam logic [1:0] ORD_LT = 2'b11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_LD_B,
    ST_RED_B,
    ST_CAP_B,
    ST_EXEC,
    ST_MUL0,
    ST_MUL1,
    ST_MUL_DONE,
    ST_EU_CHK,
    ST_EU0,
    ST_EU1,
    ST_EU_UPD,
    ST_FINISH
  } state_t;

  // serial divider control
  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  // horner accumulator control
  typedef struct packed {
    logic clr;
    logic dbl;
    logic add;
  } mul_ctl_t;

  // (x + y) mod m for x, y below m
  function automatic word_t add_mod(word_t x, word_t y, word_t m);
    logic [WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[WIDTH-1:0];
  endfunction

  // (x - y) mod m for x, y below m
  function automatic word_t sub_mod(word_t x, word_t y, word_t m);
    word_t d;
    d = x - y;
    if (x < y) d = d + m;
    return d;
  endfunction

endpackage
`default_nettype wire

@@ rtl/mppa_divser.sv @@
`default_nettype none
// restoring divider, one quotient bit per step, msb first
module mppa_divser (
  input  wire                     clk,
  input  mppa_pkg::div_ctl_t      ctl,
  input  mppa_pkg::word_t         num_in,
  input  mppa_pkg::word_t         den_in,
  output logic                    q_bit,
  output logic                    num_msb,
  output mppa_pkg::word_t         rem
);

  mppa_pkg::word_t rem_r, rem_nxt;
  mppa_pkg::word_t num_r, num_nxt;
  mppa_pkg::word_t den_r, den_nxt;
  logic [mppa_pkg::WIDTH:0] trial;
  logic [mppa_pkg::WIDTH:0] diff;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial   = {rem_r, num_r[mppa_pkg::WIDTH-1]};
    diff    = trial - {1'b0, den_r};
    q_bit   = (trial >= {1'b0, den_r});
    rem_nxt = rem_r;
    num_nxt = num_r;
    den_nxt = den_r;
    if (ctl.load) begin
      rem_nxt = '0;
      num_nxt = num_in;
      den_nxt = den_in;
    end else if (ctl.step) begin
      rem_nxt = q_bit ? diff[mppa_pkg::WIDTH-1:0] : trial[mppa_pkg::WIDTH-1:0];
      num_nxt = {num_r[mppa_pkg::WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign num_msb = num_r[mppa_pkg::WIDTH-1];
  assign rem     = rem_r;

endmodule
`default_nettype wire

@@ rtl/mppa_mulser.sv @@
`default_nettype none
// modular horner accumulator: acc = 2*acc or acc + x, both mod m
module mppa_mulser (
  input  wire                     clk,
  input  mppa_pkg::mul_ctl_t      ctl,
  input  mppa_pkg::word_t         x_in,
  input  mppa_pkg::word_t         m_in,
  output mppa_pkg::word_t         acc
);

  mppa_pkg::word_t acc_r, acc_nxt;

  // one modular add per cycle
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.dbl) begin
      acc_nxt = mppa_pkg::add_mod(acc_r, acc_r, m_in);
    end else if (ctl.add) begin
      acc_nxt = mppa_pkg::add_mod(acc_r, x_in, m_in);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

@@ rtl/modular_prime_power_alu.sv @@
`default_nettype none
// Modular arithmetic unit: add, subtract, multiply, divide, negate and compare on residues
// modulo the value written on cfg_wdata (reset value 3). One request is worked at a time;
// a new request is taken while the previous result still waits on the output. Compare,
// unused op codes and any request under a modulus below two skip the serial datapath;
// add, subtract and negate run the bit-serial reduction of both operands; multiply then
// adds the serial shift-add multiplier; divide then runs extended Euclid steps (up to
// about 93 steps at 64 bits, each step a full serial division merged with the quotient
// times t product) plus one final serial multiply.
module modular_prime_power_alu (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_we,
  input  wire  [63:0]  cfg_wdata,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [127:0] in_tdata,   // operand_a[63:0], operand_b[127:64]
  input  wire  [2:0]   in_tuser,   // op[2:0]
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [71:0]  out_tdata   // residue_out[63:0], order[65:64], not_invertible[66],
                                   // result_zero[67], result_one[68], zero[71:69]
);

  localparam int W = mppa_pkg::WIDTH;

  mppa_pkg::state_t state_r, state_nxt;
  logic [mppa_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  mppa_pkg::word_t modulus_r;
  logic [mppa_pkg::OP_W-1:0] op_r, op_nxt;
  mppa_pkg::word_t a_r, a_nxt, b_r, b_nxt;
  mppa_pkg::word_t ra_r, ra_nxt, rb_r, rb_nxt;
  mppa_pkg::word_t r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  mppa_pkg::word_t x_r, x_nxt;
  logic bit_r, bit_nxt;
  mppa_pkg::word_t res_r, res_nxt;
  logic [1:0] ord_r, ord_nxt;
  logic noinv_r, noinv_nxt;

  logic out_valid_r, out_valid_nxt;
  mppa_pkg::word_t out_res_r, out_res_nxt;
  logic [1:0] out_ord_r, out_ord_nxt;
  logic out_noinv_r, out_noinv_nxt;

  mppa_pkg::div_ctl_t div_ctl;
  mppa_pkg::mul_ctl_t mul_ctl;
  mppa_pkg::word_t div_num, div_den, div_rem, acc;
  logic q_bit, num_msb;
  logic last;
  logic trivial;
  mppa_pkg::word_t in_a, in_b;

  assign in_a    = in_tdata[W-1:0];
  assign in_b    = in_tdata[mppa_pkg::FIELD_W+W-1:mppa_pkg::FIELD_W];
  assign trivial = (modulus_r < mppa_pkg::word_t'(2));
  assign last    = (cnt_r == mppa_pkg::CNT_W'(W-1));

  // modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mppa_pkg::word_t'(3);
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata[W-1:0];
    end
  end

  mppa_divser u_div (
    .clk     (clk),
    .ctl     (div_ctl),
    .num_in  (div_num),
    .den_in  (div_den),
    .q_bit   (q_bit),
    .num_msb (num_msb),
    .rem     (div_rem)
  );

  mppa_mulser u_mul (
    .clk   (clk),
    .ctl   (mul_ctl),
    .x_in  (x_r),
    .m_in  (modulus_r),
    .acc   (acc)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mppa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    op_r        <= op_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    r0_r        <= r0_nxt;
    r1_r        <= r1_nxt;
    t0_r        <= t0_nxt;
    t1_r        <= t1_nxt;
    x_r         <= x_nxt;
    bit_r       <= bit_nxt;
    res_r       <= res_nxt;
    ord_r       <= ord_nxt;
    noinv_r     <= noinv_nxt;
    out_res_r   <= out_res_nxt;
    out_ord_r   <= out_ord_nxt;
    out_noinv_r <= out_noinv_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    x_nxt         = x_r;
    bit_nxt       = bit_r;
    res_nxt       = res_r;
    ord_nxt       = ord_r;
    noinv_nxt     = noinv_r;
    out_res_nxt   = out_res_r;
    out_ord_nxt   = out_ord_r;
    out_noinv_nxt = out_noinv_r;
    out_valid_nxt = out_valid_r && !out_tready;
    div_ctl       = '0;
    mul_ctl       = '0;
    div_num       = a_r;
    div_den       = modulus_r;
    in_tready     = 1'b0;

    unique case (state_r)
      mppa_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          a_nxt     = in_a;
          b_nxt     = in_b;
          res_nxt   = '0;
          ord_nxt   = mppa_pkg::ORD_EQ;
          noinv_nxt = 1'b0;
          cnt_nxt   = '0;
          if (in_tuser == mppa_pkg::OP_CMP) begin
            ord_nxt   = (in_a < in_b) ? mppa_pkg::ORD_LT :
                        (in_a > in_b) ? mppa_pkg::ORD_GT : mppa_pkg::ORD_EQ;
            state_nxt = mppa_pkg::ST_FINISH;
          end else if (in_tuser > mppa_pkg::OP_CMP || trivial) begin
            state_nxt = mppa_pkg::ST_FINISH;
          end else begin
            div_ctl.load = 1'b1;
            div_num      = in_a;
            state_nxt    = mppa_pkg::ST_RED_A;
          end
        end
      end
      // reduce operand a modulo m
      mppa_pkg::ST_RED_A: begin
        div_ctl.step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (last) state_nxt = mppa_pkg::ST_LD_B;
      end
      mppa_pkg::ST_LD_B: begin
        ra_nxt       = div_rem;
        div_ctl.load = 1'b1;
        div_num      = b_r;
        cnt_nxt      = '0;
        state_nxt    = mppa_pkg::ST_RED_B;
      end
      // reduce operand b modulo m
      mppa_pkg::ST_RED_B: begin
        div_ctl.step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (last) state_nxt = mppa_pkg::ST_CAP_B;
      end
      mppa_pkg::ST_CAP_B: begin
        rb_nxt    = div_rem;
        state_nxt = mppa_pkg::ST_EXEC;
      end
      mppa_pkg::ST_EXEC: begin
        cnt_nxt   = '0;
        state_nxt = mppa_pkg::ST_FINISH;
        case (op_r)
          mppa_pkg::OP_ADD: res_nxt = mppa_pkg::add_mod(ra_r, rb_r, modulus_r);
          mppa_pkg::OP_SUB: res_nxt = mppa_pkg::sub_mod(ra_r, rb_r, modulus_r);
          mppa_pkg::OP_NEG: res_nxt = (ra_r == '0) ? '0 : modulus_r - ra_r;
          mppa_pkg::OP_MUL: begin
            x_nxt        = ra_r;
            div_ctl.load = 1'b1;
            div_num      = rb_r;
            mul_ctl.clr  = 1'b1;
            state_nxt    = mppa_pkg::ST_MUL0;
          end
          mppa_pkg::OP_DIV: begin
            r0_nxt    = modulus_r;
            r1_nxt    = rb_r;
            t0_nxt    = '0;
            t1_nxt    = mppa_pkg::word_t'(1);
            state_nxt = mppa_pkg::ST_EU_CHK;
          end
          default: res_nxt = '0;
        endcase
      end
      // shift-add multiply, multiplier bits taken from the divider's shift register
      mppa_pkg::ST_MUL0: begin
        mul_ctl.dbl  = 1'b1;
        div_ctl.step = 1'b1;
        bit_nxt      = num_msb;
        state_nxt    = mppa_pkg::ST_MUL1;
      end
      mppa_pkg::ST_MUL1: begin
        mul_ctl.add = bit_r;
        cnt_nxt     = cnt_r + 1'b1;
        state_nxt   = last ? mppa_pkg::ST_MUL_DONE : mppa_pkg::ST_MUL0;
      end
      mppa_pkg::ST_MUL_DONE: begin
        res_nxt   = acc;
        state_nxt = mppa_pkg::ST_FINISH;
      end
      // extended euclid: loop test, final multiply or failure
      mppa_pkg::ST_EU_CHK: begin
        cnt_nxt = '0;
        if (r1_r == '0) begin
          if (r0_r == mppa_pkg::word_t'(1)) begin
            x_nxt        = ra_r;
            div_ctl.load = 1'b1;
            div_num      = t0_r;
            mul_ctl.clr  = 1'b1;
            state_nxt    = mppa_pkg::ST_MUL0;
          end else begin
            noinv_nxt = 1'b1;
            res_nxt   = '0;
            state_nxt = mppa_pkg::ST_FINISH;
          end
        end else begin
          x_nxt        = t1_r;
          div_ctl.load = 1'b1;
          div_num      = r0_r;
          div_den      = r1_r;
          mul_ctl.clr  = 1'b1;
          state_nxt    = mppa_pkg::ST_EU0;
        end
      end
      // quotient bit and horner doubling of q * t1
      mppa_pkg::ST_EU0: begin
        div_ctl.step = 1'b1;
        mul_ctl.dbl  = 1'b1;
        bit_nxt      = q_bit;
        state_nxt    = mppa_pkg::ST_EU1;
      end
      mppa_pkg::ST_EU1: begin
        mul_ctl.add = bit_r;
        cnt_nxt     = cnt_r + 1'b1;
        state_nxt   = last ? mppa_pkg::ST_EU_UPD : mppa_pkg::ST_EU0;
      end
      mppa_pkg::ST_EU_UPD: begin
        r0_nxt    = r1_r;
        r1_nxt    = div_rem;
        t0_nxt    = t1_r;
        t1_nxt    = mppa_pkg::sub_mod(t0_r, acc, modulus_r);
        state_nxt = mppa_pkg::ST_EU_CHK;
      end
      // hand the result to the output register
      mppa_pkg::ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_res_nxt   = res_r;
          out_ord_nxt   = ord_r;
          out_noinv_nxt = noinv_r;
          out_valid_nxt = 1'b1;
          state_nxt     = mppa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mppa_pkg::ST_IDLE;
    endcase
  end

  // output payload
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       (out_res_r == mppa_pkg::word_t'(1)),
                       (out_res_r == '0),
                       out_noinv_r,
                       out_ord_r,
                       mppa_pkg::FIELD_W'(out_res_r)};

endmodule
`default_nettype wire

@@ rtl/mppa_checker.sv @@
`default_nettype none
// port-level checks on the result stream
module mppa_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [71:0]  out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // zero flag tracks the residue
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[67] == (out_tdata[63:0] == 64'd0))
    else $error("zero flag mismatch");

  // one flag tracks the residue
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[68] == (out_tdata[63:0] == 64'd1))
    else $error("one flag mismatch");

  // a compare result carries no residue and no divide flag
  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[65:64] != 2'b00) |->
      (out_tdata[63:0] == 64'd0) && !out_tdata[66] && (out_tdata[65:64] != 2'b10))
    else $error("compare result malformed");

  // a failed divide returns zero
  a_noinv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[66] |-> (out_tdata[63:0] == 64'd0) && (out_tdata[65:64] == 2'b00))
    else $error("failed divide returned data");

endmodule

bind modular_prime_power_alu mppa_checker u_mppa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
